### rtl/gpc_pkg.sv
// Package for the grid path counter: sizes, action codes, controller states,
// the chain link type and the modular add. Depends on nothing.

package gpc_pkg;

  // Grid geometry
  localparam int unsigned MAX_DIM = 256;
  localparam int unsigned DIM_AW  = $clog2(MAX_DIM);
  localparam int unsigned COORD_W = 9;
  localparam int unsigned CNT_W   = 30;

  // Counts are kept modulo this prime
  localparam logic [CNT_W-1:0] PATH_MOD = CNT_W'(1000000007);

  // Configuration register indexes (APB word addresses)
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_RUN   = 2'd2
  } action_e;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MARK_RD = 6'b000010,
    ST_MARK_WR = 6'b000100,
    ST_RUN_RD  = 6'b001000,
    ST_RUN_GO  = 6'b010000,
    ST_RUN_ROW = 6'b100000
  } state_e;

  // Token handed from one cell to the next: a go flag and the left count
  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] left;
  } cell_link_t;

  // Per-cell static controls
  typedef struct packed {
    logic init;
    logic seed;
    logic last;
    logic blk;
  } cell_ctl_t;

  // Coordinate lies inside 1..MAX_DIM
  function automatic logic in_grid(input logic [COORD_W-1:0] v);
    in_grid = (v != '0) && ({1'b0, v} <= (COORD_W+1)'(MAX_DIM));
  endfunction

  // a + b mod PATH_MOD, both operands below PATH_MOD
  function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PATH_MOD}) begin
      s = s - {1'b0, PATH_MOD};
    end
    mod_add = s[CNT_W-1:0];
  endfunction

endpackage

### rtl/grid_path_count_with_obstacles_core.sv
// Top level of the grid path counter: APB registers, sequencer, obstacle
// map RAM and the chain of column cells. Depends on gpc_pkg, gpc_ram, gpc_cell.

// Counts right/down paths from (1,1) to (target_rows, target_cols) modulo
// 1000000007, skipping blocked cells. A clear request completes on acceptance;
// a mark request steps through accept, row read and row write. A run walks a
// token along the cell chain one column per cycle, row by row, for grids up to
// 256 x 256; the result appears on path_count_o for exactly one cycle with
// path_count_valid_o high, and must be taken then. A run with a target outside
// 1..256 returns 0 the cycle after the request. busy is high while a mark or
// run is in progress; start is ignored then. Configuration writes are only
// legal while busy is low.

module grid_path_count_with_obstacles_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action_i,
  input  logic [gpc_pkg::COORD_W-1:0] cell_row_i,
  input  logic [gpc_pkg::COORD_W-1:0] cell_col_i,
  // result
  output logic                        path_count_valid_o,
  output logic [gpc_pkg::CNT_W-1:0]   path_count_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import gpc_pkg::*;

  state_e state_q, state_d;

  logic [COORD_W-1:0] rows_q, cols_q;
  logic               cfg_wr;

  logic [DIM_AW-1:0]  mark_row_q, mark_col_q;
  logic [DIM_AW-1:0]  row_idx_q, row_idx_d;
  logic               row_vld_q [MAX_DIM];
  logic               rowv_q;

  logic               ram_en, ram_we;
  logic [DIM_AW-1:0]  ram_addr;
  logic [MAX_DIM-1:0] ram_wdata, ram_rdata, row_bits;

  logic               req_acc, run_ok, init_cells, row_done, last_row;
  logic [MAX_DIM-1:0] fin_vec;
  cell_link_t         link [MAX_DIM+1];

  logic               out_vld_q, out_vld_d;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;

  // APB registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= COORD_W'(1);
      cols_q <= COORD_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROWS: rows_q <= pwdata[COORD_W-1:0];
        REG_COLS: cols_q <= pwdata[COORD_W-1:0];
        default:  ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_COLS) ? {{(32-COORD_W){1'b0}}, cols_q}
                                         : {{(32-COORD_W){1'b0}}, rows_q};

  // Request decode
  assign busy       = (state_q != ST_IDLE);
  assign req_acc    = start && !busy;
  assign run_ok     = in_grid(rows_q) && in_grid(cols_q);
  assign init_cells = req_acc && (action_i == ACT_RUN) && run_ok;
  assign row_done   = |fin_vec;
  assign last_row   = ({1'b0, row_idx_q} + COORD_W'(1)) == rows_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    row_idx_d = row_idx_q;
    out_vld_d = 1'b0;
    out_cnt_d = out_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          unique case (action_i)
            ACT_MARK: begin
              if (in_grid(cell_row_i) && in_grid(cell_col_i)) begin
                state_d = ST_MARK_RD;
              end
            end
            ACT_RUN: begin
              if (run_ok) begin
                state_d   = ST_RUN_RD;
                row_idx_d = '0;
              end else begin
                out_vld_d = 1'b1;
                out_cnt_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MARK_RD: state_d = ST_MARK_WR;
      ST_MARK_WR: state_d = ST_IDLE;
      ST_RUN_RD:  state_d = ST_RUN_GO;
      ST_RUN_GO:  state_d = ST_RUN_ROW;
      ST_RUN_ROW: begin
        if (row_done) begin
          if (last_row) begin
            state_d   = ST_IDLE;
            out_vld_d = 1'b1;
            out_cnt_d = link[cols_q].left;
          end else begin
            state_d   = ST_RUN_RD;
            row_idx_d = row_idx_q + DIM_AW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_idx_q <= row_idx_d;
    out_cnt_q <= out_cnt_d;
    if (req_acc) begin
      mark_row_q <= DIM_AW'(cell_row_i - COORD_W'(1));
      mark_col_q <= DIM_AW'(cell_col_i - COORD_W'(1));
    end
  end

  assign path_count_valid_o = out_vld_q;
  assign path_count_o       = out_cnt_q;

  // Row valid bits: a row never written since the last clear reads open
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIM; i++) row_vld_q[i] <= 1'b0;
    end else if (req_acc && (action_i == ACT_CLEAR)) begin
      for (int i = 0; i < MAX_DIM; i++) row_vld_q[i] <= 1'b0;
    end else if (state_q == ST_MARK_WR) begin
      row_vld_q[mark_row_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MARK_RD) begin
      rowv_q <= row_vld_q[mark_row_q];
    end else if (state_q == ST_RUN_RD) begin
      rowv_q <= row_vld_q[row_idx_q];
    end
  end

  // Obstacle map, one row of blocked bits per word
  assign ram_en    = (state_q == ST_MARK_RD) || (state_q == ST_MARK_WR) ||
                     (state_q == ST_RUN_RD);
  assign ram_we    = (state_q == ST_MARK_WR);
  assign ram_addr  = (state_q == ST_RUN_RD) ? row_idx_q : mark_row_q;
  assign row_bits  = rowv_q ? ram_rdata : '0;
  assign ram_wdata = row_bits | (MAX_DIM'(1) << mark_col_q);

  gpc_ram #(
    .WIDTH (MAX_DIM),
    .DEPTH (MAX_DIM)
  ) u_map (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Cell chain; the token enters column 1 with a left count of zero
  assign link[0].go   = (state_q == ST_RUN_GO);
  assign link[0].left = '0;

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.init = init_cells;
    assign ctl.seed = (c == 0);
    assign ctl.last = (cols_q == COORD_W'(c + 1));
    assign ctl.blk  = row_bits[c];

    gpc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .link_i (link[c]),
      .link_o (link[c+1]),
      .fin_o  (fin_vec[c])
    );
  end

endmodule

### rtl/gpc_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; used for the obstacle map.

module gpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/gpc_cell.sv
// One column cell of the path-count chain: holds the count of the cell
// above and adds the token's left count. Depends on gpc_pkg.

module gpc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gpc_pkg::cell_ctl_t  ctl_i,
  input  gpc_pkg::cell_link_t link_i,
  output gpc_pkg::cell_link_t link_o,
  output logic                fin_o
);
  import gpc_pkg::*;

  logic [CNT_W-1:0] up_q, up_d;
  logic [CNT_W-1:0] left_q;
  logic             go_q, fin_q;
  logic [CNT_W-1:0] sum;

  // Blocked cell counts zero
  assign sum = ctl_i.blk ? '0 : mod_add(link_i.left, up_q);

  // Column count: seeded at run start, updated when the token passes
  always_comb begin
    up_d = up_q;
    if (ctl_i.init) begin
      up_d = ctl_i.seed ? CNT_W'(1) : '0;
    end else if (link_i.go) begin
      up_d = sum;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q <= up_d;
    if (link_i.go) begin
      left_q <= sum;
    end
  end

  // Token moves on unless this is the last column of the grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q  <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      go_q  <= link_i.go && !ctl_i.last;
      fin_q <= link_i.go && ctl_i.last;
    end
  end

  assign link_o.go   = go_q;
  assign link_o.left = left_q;
  assign fin_o       = fin_q;

endmodule

### rtl/gpc_checker.sv
// Port-level checks for the grid path counter, bound to the top level.
// Depends on gpc_pkg and grid_path_count_with_obstacles_core.

module gpc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  action_i,
  input logic                        path_count_valid_o,
  input logic [gpc_pkg::CNT_W-1:0]   path_count_o,
  input logic                        pready
);
  import gpc_pkg::*;

  // Work only begins on an accepted request
  a_busy_needs_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // A result follows a request or the end of a busy period
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    path_count_valid_o |-> $past(busy) || $past(start))
    else $error("result without a request");

  // Counts stay reduced
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    path_count_valid_o |-> (path_count_o < PATH_MOD))
    else $error("path count not reduced");

  // A clear request never makes the block busy
  a_clear_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (action_i == ACT_CLEAR)) |=> !busy && !path_count_valid_o)
    else $error("clear request left work behind");

  // Register port never stalls
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind grid_path_count_with_obstacles_core gpc_checker u_gpc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .action_i           (action_i),
  .path_count_valid_o (path_count_valid_o),
  .path_count_o       (path_count_o),
  .pready             (pready)
);

### test/grid_path_count_with_obstacles_core_test.sv
// Self-checking testbench for the grid path counter: an in-bench path count
// predictor with a result queue, plus request and APB driver tasks.
// Depends on gpc_pkg and grid_path_count_with_obstacles_core.
`timescale 1ns / 1ps

module grid_path_count_with_obstacles_core_test;
  import gpc_pkg::*;

  // Action code the block leaves undefined; it must be ignored
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 75;
  localparam int unsigned RANDOM_RUNS = 26;

  // Path count predictor: its own obstacle map, target and pending counts
  class path_scoreboard;
    bit blocked [MAX_DIM * MAX_DIM];
    int unsigned target_rows;
    int unsigned target_cols;
    logic [CNT_W-1:0] count_q[$];
    int errors;

    function new();
      foreach (blocked[i]) blocked[i] = 1'b0;
      target_rows = 1;
      target_cols = 1;
      errors = 0;
    endfunction

    function void set_target(logic idx, logic [31:0] data);
      if (idx == REG_ROWS) begin
        target_rows = {23'b0, data[COORD_W-1:0]};
      end else begin
        target_cols = {23'b0, data[COORD_W-1:0]};
      end
    endfunction

    // Sweep the grid row by row; blocked cells hold zero
    function logic [CNT_W-1:0] count_paths();
      int unsigned row_cnt [MAX_DIM];
      int unsigned up, lft, v;
      if (target_rows == 0 || target_rows > MAX_DIM ||
          target_cols == 0 || target_cols > MAX_DIM) begin
        return '0;
      end
      foreach (row_cnt[i]) row_cnt[i] = 0;
      for (int unsigned r = 0; r < target_rows; r++) begin
        lft = 0;
        for (int unsigned c = 0; c < target_cols; c++) begin
          up = (r == 0 && c == 0) ? 1 : row_cnt[c];
          if (blocked[r * MAX_DIM + c]) begin
            v = 0;
          end else begin
            v = lft + up;
            if (v >= int'(PATH_MOD)) v -= int'(PATH_MOD);
          end
          row_cnt[c] = v;
          lft = v;
        end
      end
      return CNT_W'(row_cnt[target_cols - 1]);
    endfunction

    function void note_request(logic [1:0] act, logic [COORD_W-1:0] row,
                               logic [COORD_W-1:0] col);
      if (act == ACT_CLEAR) begin
        foreach (blocked[i]) blocked[i] = 1'b0;
      end else if (act == ACT_MARK) begin
        if (row >= 1 && row <= MAX_DIM && col >= 1 && col <= MAX_DIM) begin
          blocked[(row - 1) * MAX_DIM + (col - 1)] = 1'b1;
        end
      end else if (act == ACT_RUN) begin
        count_q.push_back(count_paths());
      end
    endfunction

    function void check_count(logic [CNT_W-1:0] actual);
      logic [CNT_W-1:0] expected;
      if (count_q.size() == 0) begin
        $display("%0t: unexpected path_count, expected none, actual %0d",
                 $time, actual);
        errors++;
        return;
      end
      expected = count_q.pop_front();
      if (actual !== expected) begin
        $display("%0t: path_count mismatch, expected %0d, actual %0d",
                 $time, expected, actual);
        errors++;
      end
    endfunction

    function int pending();
      return count_q.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         action_i = ACT_CLEAR;
  logic [COORD_W-1:0] cell_row_i = '0;
  logic [COORD_W-1:0] cell_col_i = '0;
  logic               path_count_valid_o;
  logic [CNT_W-1:0]   path_count_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  path_scoreboard sb;
  bit          bursty;
  int unsigned burst_left;
  int unsigned counted;
  int unsigned random_runs;

  grid_path_count_with_obstacles_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .cell_row_i        (cell_row_i),
    .cell_col_i        (cell_col_i),
    .path_count_valid_o(path_count_valid_o),
    .path_count_o      (path_count_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result monitor: every strobe is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && path_count_valid_o) sb.check_count(path_count_o);
  end

  // Send one request; called and returns at a falling edge
  task automatic send_request(input logic [1:0] act, input logic [COORD_W-1:0] row,
                              input logic [COORD_W-1:0] col);
    if (bursty) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    start <= 1'b1;
    action_i <= act;
    cell_row_i <= row;
    cell_col_i <= col;
    do @(posedge clk_i); while (busy);
    sb.note_request(act, row, col);
    if (act == ACT_RUN) random_runs++;
    if (act == ACT_CLEAR || act == ACT_RUN ||
        (act == ACT_MARK && row >= 1 && row <= MAX_DIM &&
         col >= 1 && col <= MAX_DIM)) counted++;
    @(negedge clk_i);
  endtask

  // Hold off until every predicted count has come and the block is idle
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // APB write of a target register, then a read back
  task automatic config_target(input logic idx, input logic [31:0] data);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_target(idx, data);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    if (rd !== {23'b0, data[COORD_W-1:0]}) begin
      $display("%0t: register %0d read mismatch, expected %0d, actual %0d",
               $time, idx, data[COORD_W-1:0], rd);
      sb.errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // One random phase: new target, optional clear, rounds of marks and a run each
  task automatic random_phase();
    int unsigned pick, rows, cols, span_r, span_c, rounds, marks;
    logic [COORD_W-1:0] row, col;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      rows = $urandom_range(1, 12);
      cols = $urandom_range(1, 12);
    end else if (pick < 87) begin
      rows = $urandom_range(1, 40);
      cols = $urandom_range(1, 40);
    end else if (pick < 93) begin
      if ($urandom_range(0, 1)) begin
        rows = MAX_DIM;
        cols = $urandom_range(1, 3);
      end else begin
        rows = $urandom_range(1, 3);
        cols = MAX_DIM;
      end
    end else begin
      // target outside the grid
      rows = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
      cols = $urandom_range(0, 511);
    end
    drain();
    config_target(REG_ROWS, ($urandom & ~32'h1FF) | rows);
    config_target(REG_COLS, ($urandom & ~32'h1FF) | cols);
    bursty = ($urandom_range(0, 3) != 0);
    span_r = (rows >= 1 && rows <= MAX_DIM) ? rows : 8;
    span_c = (cols >= 1 && cols <= MAX_DIM) ? cols : 8;
    if ($urandom_range(0, 3) != 0) begin
      send_request(ACT_CLEAR, COORD_W'($urandom_range(0, 511)),
                   COORD_W'($urandom_range(0, 511)));
    end
    rounds = $urandom_range(1, 4);
    repeat (rounds) begin
      marks = $urandom_range(0, 3);
      repeat (marks) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          row = COORD_W'($urandom_range(1, span_r));
          col = COORD_W'($urandom_range(1, span_c));
        end else if (pick < 90) begin
          // stored but possibly outside the target
          row = COORD_W'($urandom_range(1, MAX_DIM));
          col = COORD_W'($urandom_range(1, MAX_DIM));
        end else begin
          row = $urandom_range(0, 1) ? '0 : COORD_W'($urandom_range(257, 511));
          col = COORD_W'($urandom_range(0, 511));
        end
        if ($urandom_range(0, 19) == 0) begin
          send_request(ACT_UNUSED, COORD_W'($urandom_range(0, 511)),
                       COORD_W'($urandom_range(0, 511)));
        end
        send_request(ACT_MARK, row, col);
      end
      send_request(ACT_RUN, COORD_W'($urandom_range(0, 511)),
                   COORD_W'($urandom_range(0, 511)));
    end
  endtask

  initial begin
    sb = new();
    bursty = 1'b0;
    burst_left = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset target 1x1: open start, blocked start, clear, unused action
    send_request(ACT_RUN, 9'd1, 9'd1);
    send_request(ACT_MARK, 9'd1, 9'd1);
    send_request(ACT_RUN, 9'd0, 9'd0);
    send_request(ACT_CLEAR, 9'd511, 9'd511);
    send_request(ACT_UNUSED, 9'd511, 9'd511);
    send_request(ACT_RUN, 9'd511, 9'd0);

    // Full 256x256 grid, then marks off the grid and on the target cell
    drain();
    config_target(REG_ROWS, 32'd256);
    config_target(REG_COLS, 32'd256);
    send_request(ACT_RUN, 9'd0, 9'd0);
    send_request(ACT_MARK, 9'd0, 9'd5);
    send_request(ACT_MARK, 9'd257, 9'd3);
    send_request(ACT_MARK, 9'd511, 9'd511);
    send_request(ACT_MARK, 9'd5, 9'd0);
    send_request(ACT_MARK, 9'd256, 9'd256);
    send_request(ACT_RUN, 9'd0, 9'd0);

    // Narrow strip with one obstacle and one mark beyond the target
    drain();
    config_target(REG_ROWS, 32'd3);
    send_request(ACT_CLEAR, 9'd0, 9'd0);
    send_request(ACT_MARK, 9'd2, 9'd2);
    send_request(ACT_MARK, 9'd200, 9'd200);
    send_request(ACT_RUN, 9'd0, 9'd0);

    // Targets out of range
    drain();
    config_target(REG_ROWS, 32'd0);
    send_request(ACT_RUN, 9'd0, 9'd0);
    drain();
    config_target(REG_ROWS, 32'hFFFF_FE00 | 32'd300);
    config_target(REG_COLS, 32'd511);
    send_request(ACT_RUN, 9'd0, 9'd0);

    // Single column and single row, stored marks lying outside
    drain();
    config_target(REG_ROWS, 32'd256);
    config_target(REG_COLS, 32'd1);
    send_request(ACT_MARK, 9'd128, 9'd2);
    send_request(ACT_RUN, 9'd0, 9'd0);
    drain();
    config_target(REG_ROWS, 32'd1);
    config_target(REG_COLS, 32'd256);
    send_request(ACT_RUN, 9'd0, 9'd0);

    // Random phases
    counted = 0;
    random_runs = 0;
    while (counted < RANDOM_ITEMS || random_runs < RANDOM_RUNS) random_phase();

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: %0d path counts never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
rtl/gpc_pkg.sv
rtl/gpc_ram.sv
rtl/gpc_cell.sv
rtl/grid_path_count_with_obstacles_core.sv
rtl/gpc_checker.sv
test/grid_path_count_with_obstacles_core_test.sv
